FILE: hdl/assert_macros.svh
// Assertion helpers for the RTL; included by cau_back.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked assertion, disabled while reset is high.
`define ASSERT_CLK(lbl, clk, rst, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Clocked assertion, also checked during reset.
`define ASSERT_ALWAYS(lbl, clk, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

FILE: hdl/cau_pkg.sv
`default_nettype none
package cau_pkg;

  // Raw command codes on the request channel
  localparam logic [2:0] CMD_ADD = 3'd0;
  localparam logic [2:0] CMD_SUB = 3'd1;
  localparam logic [2:0] CMD_MUL = 3'd2;
  localparam logic [2:0] CMD_DIV = 3'd3;
  localparam logic [2:0] CMD_NEG = 3'd4;
  localparam logic [2:0] CMD_EQ  = 3'd5;

  // Decoded operation class
  typedef enum logic [2:0] {
    OP_ADD,
    OP_SUB,
    OP_MUL,
    OP_DIV,
    OP_NEG,
    OP_EQ,
    OP_NOP
  } op_t;

  localparam int PW = 64;  // product / magnitude width
  localparam int RW = 96;  // divider remainder width
  localparam int QW = 32;  // quotient width

  typedef struct packed {
    logic [2:0]         cmd;
    logic signed [31:0] a_real;
    logic signed [31:0] a_imag;
    logic signed [31:0] b_real;
    logic signed [31:0] b_imag;
  } req_t;

  typedef struct packed {
    logic signed [31:0] res_real;
    logic signed [31:0] res_imag;
    logic               is_equal;
    logic               div_zero;
    logic               overflow;
  } rsp_t;

  // Classified item handed from front to back
  typedef struct packed {
    op_t                op;
    logic signed [31:0] ar;
    logic signed [31:0] ai;
    logic signed [31:0] br;
    logic signed [31:0] bi;
  } job_t;

endpackage
`default_nettype wire

FILE: hdl/complex_arithmetic_unit.sv
`default_nettype none
// Complex-number ALU on signed fixed-point parts (Q16.16 by default).
// Request channel (req_valid/req_ready/req): opcode plus operands a and b.
// Response channel (rsp_valid/rsp_ready/rsp): result parts and the
// is_equal, div_zero and overflow flags; one response per transaction, in order.
// Structure: a front stage registers and decodes each transaction, a 2-deep
// queue decouples it from the back pipeline (products, combine/divide, saturate).
// Path: front register, queue, stage 1 (products), stage 2 (combine/divide) and
// the response register (saturate); a divide with a nonzero divisor also runs
// the bit-serial divider in stage 2, holding the back pipeline while it runs.
// Throughput: one transaction per cycle while responses are taken, apart from
// those divides; the queue and front keep accepting until they fill.
// Reset (rst, synchronous) empties every stage and the queue; no state is kept
// between transactions.
// When the receiver stalls, the response register holds, the back pipeline
// freezes, and req_ready drops once the queue and front stage are full.
module complex_arithmetic_unit #(
  parameter int WORD_BITS = 32,
  parameter int FRAC_BITS = 16
) (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          req_valid,
  output logic               req_ready,
  input  wire cau_pkg::req_t req,
  output logic               rsp_valid,
  input  wire logic          rsp_ready,
  output cau_pkg::rsp_t      rsp
);

  localparam int QDEPTH = 2;

  cau_pkg::job_t f_job;
  logic          f_valid;
  logic          f_ready;
  cau_pkg::job_t q_job;
  logic          q_valid;
  logic          q_ready;

  // decode and operand sign extension
  cau_front #(.WORD_BITS(WORD_BITS)) u_front (
    .clk       (clk),
    .rst       (rst),
    .req       (req),
    .req_valid (req_valid),
    .req_ready (req_ready),
    .job       (f_job),
    .job_valid (f_valid),
    .job_ready (f_ready)
  );

  // short queue between front and back
  cau_fifo #(.DEPTH(QDEPTH)) u_queue (
    .clk      (clk),
    .rst      (rst),
    .wr_data  (f_job),
    .wr_valid (f_valid),
    .wr_ready (f_ready),
    .rd_data  (q_job),
    .rd_valid (q_valid),
    .rd_ready (q_ready)
  );

  // arithmetic, divider and saturation
  cau_back #(.WORD_BITS(WORD_BITS), .FRAC_BITS(FRAC_BITS)) u_back (
    .clk       (clk),
    .rst       (rst),
    .job       (q_job),
    .job_valid (q_valid),
    .job_ready (q_ready),
    .rsp       (rsp),
    .rsp_valid (rsp_valid),
    .rsp_ready (rsp_ready)
  );

endmodule
`default_nettype wire

FILE: hdl/cau_front.sv
`default_nettype none
module cau_front #(
  parameter int WORD_BITS = 32
) (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire cau_pkg::req_t req,
  input  wire logic          req_valid,
  output logic               req_ready,
  output cau_pkg::job_t      job,
  output logic               job_valid,
  input  wire logic          job_ready
);

  cau_pkg::op_t op_dec;

  // keep the low WORD_BITS bits, sign-extended
  function automatic logic signed [31:0] sext(input logic [31:0] x);
    logic signed [31:0] t;
    t = x << (32 - WORD_BITS);
    return t >>> (32 - WORD_BITS);
  endfunction

  always_comb begin
    unique case (req.cmd)
      cau_pkg::CMD_ADD: op_dec = cau_pkg::OP_ADD;
      cau_pkg::CMD_SUB: op_dec = cau_pkg::OP_SUB;
      cau_pkg::CMD_MUL: op_dec = cau_pkg::OP_MUL;
      cau_pkg::CMD_DIV: op_dec = cau_pkg::OP_DIV;
      cau_pkg::CMD_NEG: op_dec = cau_pkg::OP_NEG;
      cau_pkg::CMD_EQ:  op_dec = cau_pkg::OP_EQ;
      default:          op_dec = cau_pkg::OP_NOP;
    endcase
  end

  assign req_ready = !job_valid || job_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      job_valid <= 1'b0;
    end else if (req_ready) begin
      job_valid <= req_valid;
    end
    if (req_ready && req_valid) begin
      job.op <= op_dec;
      job.ar <= sext(req.a_real);
      job.ai <= sext(req.a_imag);
      job.br <= sext(req.b_real);
      job.bi <= sext(req.b_imag);
    end
  end

endmodule
`default_nettype wire

FILE: hdl/cau_fifo.sv
`default_nettype none
module cau_fifo #(
  parameter int DEPTH = 2
) (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire cau_pkg::job_t wr_data,
  input  wire logic          wr_valid,
  output logic               wr_ready,
  output cau_pkg::job_t      rd_data,
  output logic               rd_valid,
  input  wire logic          rd_ready
);

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  cau_pkg::job_t  mem [DEPTH];
  logic [AW-1:0]  wp;
  logic [AW-1:0]  rp;
  logic [CW-1:0]  count;
  logic           push;
  logic           pop;

  assign wr_ready = (count != CW'(DEPTH));
  assign rd_valid = (count != '0);
  assign rd_data  = mem[rp];
  assign push     = wr_valid && wr_ready;
  assign pop      = rd_valid && rd_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      wp    <= '0;
      rp    <= '0;
      count <= '0;
    end else begin
      if (push) begin
        wp <= (wp == AW'(DEPTH - 1)) ? '0 : wp + 1'b1;
      end
      if (pop) begin
        rp <= (rp == AW'(DEPTH - 1)) ? '0 : rp + 1'b1;
      end
      count <= count + CW'(push) - CW'(pop);
    end
    if (push) begin
      mem[wp] <= wr_data;
    end
  end

endmodule
`default_nettype wire

FILE: hdl/cau_back.sv
`default_nettype none
`include "assert_macros.svh"
module cau_back #(
  parameter int WORD_BITS = 32,
  parameter int FRAC_BITS = 16
) (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire cau_pkg::job_t job,
  input  wire logic          job_valid,
  output logic               job_ready,
  output cau_pkg::rsp_t      rsp,
  output logic               rsp_valid,
  input  wire logic          rsp_ready
);

  localparam int CNTW = $clog2(WORD_BITS + 2);
  localparam logic [cau_pkg::PW-1:0] LIM = cau_pkg::PW'(1) << (WORD_BITS - 1);

  // stage 1: products and linear results
  logic                              s1_v;
  cau_pkg::op_t                      s1_op;
  logic signed [cau_pkg::PW-1:0]     p_rr, p_ii, p_ri, p_ir, p_b1, p_b2;
  logic signed [32:0]                lin_r, lin_i;
  logic                              s1_eq;

  // stage 2: sign/magnitude, divider state
  logic                              s2_v;
  cau_pkg::op_t                      s2_op;
  logic                              neg_r, neg_i;
  logic [cau_pkg::PW-1:0]            mag_r, mag_i;
  logic                              s2_eq, s2_dz;
  logic [cau_pkg::RW-1:0]            dsh, rem_r, rem_i;
  logic [cau_pkg::QW-1:0]            q_r, q_i;
  logic                              big_r, big_i;
  logic [CNTW-1:0]                   cnt;

  logic                              adv;
  logic signed [32:0]                lin_r_n, lin_i_n;
  logic signed [cau_pkg::PW:0]       vr, vi;
  logic [cau_pkg::PW-1:0]            am_r, am_i, m_sum;
  logic                              ge_r, ge_i;
  logic [cau_pkg::PW-1:0]            fm_r, fm_i;
  logic                              fb_r, fb_i;
  logic [32:0]                       sat_r, sat_i;

  // {overflow, value}
  function automatic logic [32:0] sat(input logic neg, input logic big,
                                      input logic [cau_pkg::PW-1:0] m);
    logic [cau_pkg::PW-1:0] r;
    logic                   o;
    o = 1'b0;
    if (m == '0 && !big) begin
      r = '0;
    end else if (!neg) begin
      if (big || m > LIM - 1'b1) begin
        o = 1'b1;
        r = LIM - 1'b1;
      end else begin
        r = m;
      end
    end else begin
      if (big || m > LIM) begin
        o = 1'b1;
        r = '0 - LIM;
      end else begin
        r = '0 - m;
      end
    end
    return {o, r[31:0]};
  endfunction

  // whole back pipeline moves together; a running divide holds it
  assign adv       = (!rsp_valid || rsp_ready) && !(s2_v && cnt != '0);
  assign job_ready = adv;

  always_comb begin
    unique case (job.op)
      cau_pkg::OP_ADD: begin
        lin_r_n = 33'(job.ar) + 33'(job.br);
        lin_i_n = 33'(job.ai) + 33'(job.bi);
      end
      cau_pkg::OP_SUB: begin
        lin_r_n = 33'(job.ar) - 33'(job.br);
        lin_i_n = 33'(job.ai) - 33'(job.bi);
      end
      cau_pkg::OP_NEG: begin
        lin_r_n = -33'(job.ar);
        lin_i_n = -33'(job.ai);
      end
      default: begin
        lin_r_n = '0;
        lin_i_n = '0;
      end
    endcase
  end

  always_comb begin
    unique case (s1_op)
      cau_pkg::OP_MUL: begin
        vr = 65'(p_rr) - 65'(p_ii);
        vi = 65'(p_ri) + 65'(p_ir);
      end
      cau_pkg::OP_DIV: begin
        vr = 65'(p_rr) + 65'(p_ii);
        vi = 65'(p_ir) - 65'(p_ri);
      end
      cau_pkg::OP_ADD, cau_pkg::OP_SUB, cau_pkg::OP_NEG: begin
        vr = 65'(lin_r);
        vi = 65'(lin_i);
      end
      default: begin
        vr = '0;
        vi = '0;
      end
    endcase
    am_r  = vr[cau_pkg::PW] ? cau_pkg::PW'(-vr) : vr[cau_pkg::PW-1:0];
    am_i  = vi[cau_pkg::PW] ? cau_pkg::PW'(-vi) : vi[cau_pkg::PW-1:0];
    m_sum = cau_pkg::PW'(p_b1) + cau_pkg::PW'(p_b2);
  end

  assign ge_r = (rem_r >= dsh);
  assign ge_i = (rem_i >= dsh);

  always_comb begin
    if (s2_op == cau_pkg::OP_DIV) begin
      fm_r = s2_dz ? '0 : cau_pkg::PW'(q_r);
      fm_i = s2_dz ? '0 : cau_pkg::PW'(q_i);
      fb_r = !s2_dz && big_r;
      fb_i = !s2_dz && big_i;
    end else begin
      fm_r = mag_r;
      fm_i = mag_i;
      fb_r = 1'b0;
      fb_i = 1'b0;
    end
    sat_r = sat(neg_r, fb_r, fm_r);
    sat_i = sat(neg_i, fb_i, fm_i);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_v      <= 1'b0;
      s2_v      <= 1'b0;
      rsp_valid <= 1'b0;
      cnt       <= '0;
    end else begin
      if (adv) begin
        s1_v      <= job_valid;
        s2_v      <= s1_v;
        rsp_valid <= s2_v;
        cnt       <= (s1_v && s1_op == cau_pkg::OP_DIV && m_sum != '0) ?
                     CNTW'(WORD_BITS + 1) : '0;
      end else begin
        // a response can still leave while the divider runs
        if (rsp_ready) begin
          rsp_valid <= 1'b0;
        end
        if (s2_v && cnt != '0) begin
          cnt <= cnt - 1'b1;
        end
      end
    end

    if (adv) begin
      s1_op <= job.op;
      p_rr  <= cau_pkg::PW'(job.ar) * cau_pkg::PW'(job.br);
      p_ii  <= cau_pkg::PW'(job.ai) * cau_pkg::PW'(job.bi);
      p_ri  <= cau_pkg::PW'(job.ar) * cau_pkg::PW'(job.bi);
      p_ir  <= cau_pkg::PW'(job.ai) * cau_pkg::PW'(job.br);
      p_b1  <= cau_pkg::PW'(job.br) * cau_pkg::PW'(job.br);
      p_b2  <= cau_pkg::PW'(job.bi) * cau_pkg::PW'(job.bi);
      lin_r <= lin_r_n;
      lin_i <= lin_i_n;
      s1_eq <= (job.op == cau_pkg::OP_EQ) && (job.ar == job.br) && (job.ai == job.bi);

      s2_op <= s1_op;
      s2_eq <= s1_eq;
      s2_dz <= (s1_op == cau_pkg::OP_DIV) && (m_sum == '0);
      neg_r <= vr[cau_pkg::PW];
      neg_i <= vi[cau_pkg::PW];
      mag_r <= (s1_op == cau_pkg::OP_MUL) ? (am_r >> FRAC_BITS) : am_r;
      mag_i <= (s1_op == cau_pkg::OP_MUL) ? (am_i >> FRAC_BITS) : am_i;
      dsh   <= cau_pkg::RW'(m_sum) << WORD_BITS;
      rem_r <= cau_pkg::RW'(am_r) << FRAC_BITS;
      rem_i <= cau_pkg::RW'(am_i) << FRAC_BITS;
      q_r   <= '0;
      q_i   <= '0;
      big_r <= 1'b0;
      big_i <= 1'b0;

      rsp.res_real <= sat_r[31:0];
      rsp.res_imag <= sat_i[31:0];
      rsp.overflow <= sat_r[32] || sat_i[32];
      rsp.is_equal <= s2_eq;
      rsp.div_zero <= s2_dz;
    end else if (s2_v && cnt != '0) begin
      // one restoring step per cycle; the first step only detects a too-large quotient
      rem_r <= ge_r ? rem_r - dsh : rem_r;
      rem_i <= ge_i ? rem_i - dsh : rem_i;
      q_r   <= {q_r[cau_pkg::QW-2:0], ge_r};
      q_i   <= {q_i[cau_pkg::QW-2:0], ge_i};
      dsh   <= dsh >> 1;
      if (cnt == CNTW'(WORD_BITS + 1)) begin
        big_r <= ge_r;
        big_i <= ge_i;
      end
    end
  end

  `ASSERT_CLK(a_cnt_div, clk, rst, (cnt != '0) |-> (s2_v && s2_op == cau_pkg::OP_DIV), "divider running without a divide in stage 2")
  `ASSERT_CLK(a_dz_clean, clk, rst, (rsp_valid && rsp.div_zero) |-> (!rsp.overflow && rsp.res_real == 0 && rsp.res_imag == 0), "zero divisor result not clean")
  `ASSERT_CLK(a_div_hold, clk, rst, (s2_v && cnt != '0) |-> !job_ready, "back accepted work while dividing")

endmodule
`default_nettype wire
